// ===== hdl/lrn_pkg.sv =====
// lrn_pkg: types, codes and constant tables for the channel normalizer
// used by lrn_cell, lrn_norm and lrn_across_channels; no dependencies
package lrn_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SQ_W     = 2 * SAMPLE_W;
  localparam int MAG_W    = SAMPLE_W + 1;
  localparam int CFG_W    = 32;
  localparam int PEND_W   = 5;
  localparam int LOG_STEPS = 16;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_WINDOW = 2'd0;
  localparam reg_idx_t REG_ALPHA  = 2'd1;
  localparam reg_idx_t REG_BETA   = 2'd2;
  localparam reg_idx_t REG_BIAS   = 2'd3;

  typedef struct packed {
    logic [3:0]  win;
    logic [31:0] alpha;
    logic [15:0] beta;
    logic [31:0] bias;
  } lrn_cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                sat;
  } lrn_res_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_FLUSH, S_FSTART, S_NORM, S_OUT
  } top_state_t;

  typedef enum logic [3:0] {
    N_IDLE, N_ADD, N_LZ, N_LOG, N_BETA, N_EXP, N_RMUL, N_FIN
  } norm_state_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v   = n;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // 2^(2^-n) in Q1.30
  function automatic logic [30:0] exp_const(input int n);
    logic [63:0] c;
    c = isqrt64(64'd1 << 61);
    for (int k = 1; k < 16; k++) begin
      if (k < n) c = isqrt64(c << 30);
    end
    return c[30:0];
  endfunction

  localparam logic [30:0] EXP_C [16] = '{
    exp_const(1),  exp_const(2),  exp_const(3),  exp_const(4),
    exp_const(5),  exp_const(6),  exp_const(7),  exp_const(8),
    exp_const(9),  exp_const(10), exp_const(11), exp_const(12),
    exp_const(13), exp_const(14), exp_const(15), exp_const(16)
  };

endpackage

// ===== hdl/lrn_cell.sv =====
// lrn_cell: one window position, holding a squared sample and its raw sample
// depends on lrn_pkg
module lrn_cell import lrn_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       shift,
  input  logic                       clr,
  input  logic [SQ_W-1:0]            sq_in,
  input  logic signed [SAMPLE_W-1:0] smp_in,
  output logic [SQ_W-1:0]            sq_out,
  output logic signed [SAMPLE_W-1:0] smp_out
);

  logic [SQ_W-1:0]            sq_r;
  logic signed [SAMPLE_W-1:0] smp_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      sq_r  <= '0;
      smp_r <= '0;
    end else if (shift) begin
      sq_r  <= sq_in;
      smp_r <= smp_in;
    end
  end

  assign sq_out  = sq_r;
  assign smp_out = smp_r;

endmodule

// ===== hdl/lrn_norm.sv =====
// lrn_norm: sequencer for x * (k + a*sum)^-beta via log2 / exp2 steps
// depends on lrn_pkg
module lrn_norm import lrn_pkg::*; #(
  parameter int SUM_W = 36
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [SAMPLE_W-1:0] x,
  input  logic [SUM_W-1:0]           sum,
  input  lrn_cfg_t                   cfg,
  output logic                       done,
  output lrn_res_t                   res
);

  localparam int S_W  = SUM_W + 1;

  norm_state_t st_r, st_nxt;
  logic [4:0]        cnt_r;
  logic [MAG_W-1:0]  mag_r;
  logic              neg_r;
  logic [63:0]       alo_r;
  logic [SUM_W-1:0]  ahi_r;
  logic [S_W-1:0]    norm_r;
  logic [5:0]        e_r;
  logic [30:0]       m_r;
  logic [15:0]       frac_r;
  logic signed [26:0] e16_r;
  logic [30:0]       f_r;
  logic [47:0]       r_r;
  logic              zero_r;
  lrn_res_t          res_r;
  logic              done_r;

  logic [S_W-1:0]     s_sum;
  logic [63:0]        msq;
  logic [31:0]        mt;
  logic signed [23:0] lg;
  logic signed [40:0] bprod;
  logic signed [40:0] e16_full;
  logic [61:0]        fprod;
  logic signed [11:0] sh;
  logic [11:0]        kneg;
  logic [63:0]        r2;
  logic [63:0]        rr;
  logic               sat;
  logic [MAG_W-1:0]   lim;

  always_comb begin
    s_sum    = S_W'(cfg.bias) + S_W'(ahi_r) + S_W'(alo_r[63:32]);
    msq      = 64'(m_r) * 64'(m_r);
    mt       = msq[61:30];
    lg       = {8'({2'b00, e_r} - 8'd16), frac_r};
    bprod    = 41'(signed'({1'b0, cfg.beta})) * 41'(lg);
    e16_full = (-bprod) >>> 14;
    fprod    = 62'(f_r) * 62'(EXP_C[cnt_r[3:0]]);
    sh       = 12'sd30 - {e16_r[26], e16_r[26:16]};
    kneg     = 12'(-sh);
    lim      = neg_r ? (MAG_W'(1) << (SAMPLE_W - 1)) : ((MAG_W'(1) << (SAMPLE_W - 1)) - MAG_W'(1));
    sat      = 1'b0;
    rr       = '0;
    r2       = '0;
    if (zero_r) begin
      if (cfg.beta == '0) r2 = 64'(mag_r);
      else if (mag_r == '0) r2 = '0;
      else begin
        r2  = 64'(lim);
        sat = 1'b1;
      end
    end else if (sh >= 12'sd48) begin
      r2 = '0;
    end else if (sh >= 12'sd1) begin
      rr = 64'(r_r) + (64'd1 << (sh[5:0] - 6'd1));
      r2 = rr >> sh[5:0];
    end else if (r_r != '0 && kneg >= 12'd16) begin
      r2  = 64'(lim);
      sat = 1'b1;
    end else begin
      r2 = 64'(r_r) << kneg[3:0];
    end
    if (r2 > 64'(lim)) begin
      r2  = 64'(lim);
      sat = 1'b1;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      N_IDLE:  if (start) st_nxt = N_ADD;
      N_ADD:   st_nxt = (s_sum == '0) ? N_FIN : N_LZ;
      N_LZ:    if (norm_r[S_W-1]) st_nxt = N_LOG;
      N_LOG:   if (cnt_r == 5'(LOG_STEPS - 1)) st_nxt = N_BETA;
      N_BETA:  st_nxt = N_EXP;
      N_EXP:   if (cnt_r == 5'(LOG_STEPS - 1)) st_nxt = N_RMUL;
      N_RMUL:  st_nxt = N_FIN;
      N_FIN:   st_nxt = N_IDLE;
      default: st_nxt = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= N_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == N_FIN);
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      N_IDLE: begin
        neg_r <= x[SAMPLE_W-1];
        mag_r <= x[SAMPLE_W-1] ? MAG_W'(-{x[SAMPLE_W-1], x}) : MAG_W'({1'b0, x});
        alo_r <= 64'(cfg.alpha) * 64'(sum[31:0]);
        ahi_r <= SUM_W'(cfg.alpha) * SUM_W'(sum[SUM_W-1:32]);
      end
      N_ADD: begin
        norm_r <= s_sum;
        e_r    <= 6'(S_W - 1);
        zero_r <= (s_sum == '0);
      end
      N_LZ: begin
        if (norm_r[S_W-1]) begin
          m_r    <= norm_r[S_W-1 -: 31];
          cnt_r  <= '0;
          frac_r <= '0;
        end else begin
          norm_r <= norm_r << 1;
          e_r    <= e_r - 6'd1;
        end
      end
      N_LOG: begin
        frac_r <= {frac_r[14:0], mt[31]};
        m_r    <= mt[31] ? mt[31:1] : mt[30:0];
        cnt_r  <= cnt_r + 5'd1;
      end
      N_BETA: begin
        e16_r <= e16_full[26:0];
        f_r   <= 31'd1 << 30;
        cnt_r <= '0;
      end
      N_EXP: begin
        if (e16_r[4'd15 - cnt_r[3:0]]) f_r <= fprod[60:30];
        cnt_r <= cnt_r + 5'd1;
      end
      N_RMUL: r_r <= 48'(mag_r) * 48'(f_r);
      N_FIN: begin
        res_r.sample <= neg_r ? SAMPLE_W'(-r2) : r2[SAMPLE_W-1:0];
        res_r.sat    <= sat;
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// ===== hdl/lrn_across_channels.sv =====
// lrn_across_channels: top level, chain of window cells, stream control, output word
// depends on lrn_pkg, lrn_cell, lrn_norm
// Each channel word enters a chain of MAX_WINDOW cells that shift squared samples
// and raw samples one place per accepted word or flush step, with a running window
// sum. A word that produces no result goes from the check state back to idle. Each
// result runs through the normalizer sequencer (a leading-one search, then 16 log2
// squaring steps and 16 exp2 product steps on separate multipliers, all skipped
// when the scale is zero) and then waits on the output register while it is held.
// A last-channel word flushes the pending channels one result at a time. A new
// word can be accepted while a finished result waits in the output register.
// Reset clears the chain at once; there is no clearing pass.
module lrn_across_channels import lrn_pkg::*; #(
  parameter int MAX_WINDOW = 15
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  input  logic                       in_last_channel,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                       out_last,
  output logic                       out_saturated,
  input  logic                       cfg_we,
  input  reg_idx_t                   cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  localparam int LARGEST_ODD = (MAX_WINDOW % 2 == 1) ? MAX_WINDOW : MAX_WINDOW - 1;
  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W = SQ_W + $clog2(MAX_WINDOW + 1);

  top_state_t state_r, state_nxt;
  lrn_cfg_t   cfg_r;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic              last_r, last_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              out_valid_r;
  lrn_res_t          out_res_r;
  logic              out_last_r;

  logic push, flush, clr_stream, norm_start, load_out, norm_done;
  lrn_res_t norm_res;
  logic [4:0] weff;
  logic [4:0] wm1;
  logic [4:0] p;
  logic [SQ_W-1:0] sq_new;
  logic signed [SAMPLE_W-1:0] smp_new;
  logic [SQ_W-1:0]            sq_c  [MAX_WINDOW];
  logic signed [SAMPLE_W-1:0] smp_c [MAX_WINDOW];

  always_comb begin
    weff = {1'b0, cfg_r.win | 4'd1};
    if (weff > 5'(LARGEST_ODD)) weff = 5'(LARGEST_ODD);
    wm1 = weff - 5'd1;
    p   = weff >> 1;
  end

  assign smp_new = flush ? '0 : in_sample_in;
  assign sq_new  = SQ_W'(smp_new * smp_new);

  for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
    if (j == 0) begin : g_head
      lrn_cell u_cell (
        .clk(clk), .rst_n(rst_n), .shift(push), .clr(clr_stream),
        .sq_in(sq_new), .smp_in(smp_new), .sq_out(sq_c[j]), .smp_out(smp_c[j])
      );
    end else begin : g_body
      lrn_cell u_cell (
        .clk(clk), .rst_n(rst_n), .shift(push), .clr(clr_stream),
        .sq_in(sq_c[j-1]), .smp_in(smp_c[j-1]), .sq_out(sq_c[j]), .smp_out(smp_c[j])
      );
    end
  end

  lrn_norm #(.SUM_W(SUM_W)) u_norm (
    .clk(clk), .rst_n(rst_n), .start(norm_start), .x(smp_c[p[IDX_W-1:0]]),
    .sum(sum_r), .cfg(cfg_r), .done(norm_done), .res(norm_res)
  );

  always_comb begin
    state_nxt  = state_r;
    pend_nxt   = pend_r;
    last_nxt   = last_r;
    push       = 1'b0;
    flush      = 1'b0;
    clr_stream = 1'b0;
    norm_start = 1'b0;
    load_out   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          push      = 1'b1;
          pend_nxt  = pend_r + PEND_W'(1);
          last_nxt  = in_last_channel;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (pend_r > p) begin
          norm_start = 1'b1;
          pend_nxt   = pend_r - PEND_W'(1);
          state_nxt  = S_NORM;
        end else if (last_r) begin
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FLUSH: begin
        push      = 1'b1;
        flush     = 1'b1;
        state_nxt = S_FSTART;
      end
      S_FSTART: begin
        norm_start = 1'b1;
        pend_nxt   = pend_r - PEND_W'(1);
        state_nxt  = S_NORM;
      end
      S_NORM: if (norm_done) state_nxt = S_OUT;
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          load_out = 1'b1;
          if (last_r && pend_r != '0) begin
            state_nxt = S_FLUSH;
          end else begin
            clr_stream = last_r;
            state_nxt  = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_we && cfg_index == REG_WINDOW) clr_stream = 1'b1;
    if (clr_stream) pend_nxt = '0;
  end

  always_comb begin
    sum_nxt = sum_r;
    if (clr_stream) sum_nxt = '0;
    else if (push) sum_nxt = sum_r - SUM_W'(sq_c[wm1[IDX_W-1:0]]) + SUM_W'(sq_new);
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= '0;
      last_r      <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      cfg_r.win   <= 4'd5;
      cfg_r.alpha <= 32'd85899;
      cfg_r.beta  <= 16'd12288;
      cfg_r.bias  <= 32'd65536;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      last_r  <= last_nxt;
      sum_r   <= sum_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW: cfg_r.win   <= cfg_data[3:0];
          REG_ALPHA:  cfg_r.alpha <= cfg_data;
          REG_BETA:   cfg_r.beta  <= cfg_data[15:0];
          REG_BIAS:   cfg_r.bias  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res_r  <= norm_res;
      out_last_r <= last_r && (pend_r == '0);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sample    = out_res_r.sample;
  assign out_last      = out_last_r;
  assign out_saturated = out_res_r.sat;

  a_done_in_norm: assert property (@(posedge clk) disable iff (!rst_n)
    norm_done |-> state_r == S_NORM) else $error("normalizer done outside wait");
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= p + 5'd1) else $error("pending count beyond window");
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !cfg_we) |=> state_r == S_CHECK)
    else $error("accepted word not checked");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || !out_stall)) else $error("output word overwritten");

endmodule

// ===== tb/lrn_checker.sv =====
`timescale 1ns / 1ps
// lrn_checker: watches the word, result and register ports of lrn_across_channels,
// predicts every result and compares it field by field; depends on lrn_pkg
module lrn_checker import lrn_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  input  logic                       in_last_channel,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [SAMPLE_W-1:0] out_sample,
  input  logic                       out_last,
  input  logic                       out_saturated,
  input  logic                       cfg_we,
  input  reg_idx_t                   cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  output int                         fail_count,
  output int                         awaited
);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    logic                sat;
  } norm_word_t;

  localparam int WIN_MAX = 15;
  localparam int DLY_N   = 8;

  lrn_cfg_t    regs;
  logic [63:0] sq_win [WIN_MAX];
  longint      dly    [DLY_N];
  logic [63:0] win_sum;
  int          pend;
  norm_word_t  norm_q [$];

  assign awaited = norm_q.size();

  function automatic int eff_win();
    int w;
    w = int'(regs.win) | 1;
    if (w > WIN_MAX) w = WIN_MAX;
    return w;
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] v, res, b;
    v   = n;
    res = '0;
    b   = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic clear_stream();
    for (int j = 0; j < WIN_MAX; j++) sq_win[j] = '0;
    for (int j = 0; j < DLY_N; j++) dly[j] = 0;
    win_sum = '0;
    pend    = 0;
  endtask

  task automatic shift_in(input logic [63:0] sq, input longint x);
    int w;
    logic [63:0] old;
    w   = eff_win();
    old = sq_win[w-1];
    for (int j = w - 1; j > 0; j--) sq_win[j] = sq_win[j-1];
    sq_win[0] = sq;
    win_sum   = win_sum - old + sq;
    for (int j = DLY_N - 1; j > 0; j--) dly[j] = dly[j-1];
    dly[0] = x;
  endtask

  function automatic norm_word_t scale_sample(input longint x);
    logic [63:0] a, hi, lo, t, s, mag, lim, r, m, frac, f, c;
    logic        neg, sat;
    longint      beta, lg, e16, ei, ef, sh;
    int          e;
    norm_word_t  o;
    a    = regs.alpha;
    beta = longint'(regs.beta);
    hi   = win_sum >> 32;
    lo   = win_sum & 64'hFFFF_FFFF;
    t    = a * hi;
    s    = t + ((a * lo) >> 32);
    neg  = x < 0;
    mag  = neg ? 64'(-x) : 64'(x);
    lim  = neg ? (64'd1 << (SAMPLE_W - 1)) : ((64'd1 << (SAMPLE_W - 1)) - 1);
    sat  = 1'b0;
    if (s < t) s = '1;
    t = s + 64'(regs.bias);
    s = (t < s) ? '1 : t;
    if (s == 0) begin
      if (beta == 0) r = mag;
      else if (mag == 0) r = 0;
      else begin
        r   = lim;
        sat = 1'b1;
      end
    end else begin
      e = 63;
      while (s[e] == 1'b0) e--;
      m    = (e >= 30) ? (s >> (e - 30)) : (s << (30 - e));
      frac = 0;
      for (int i = 0; i < 16; i++) begin
        m    = (m * m) >> 30;
        frac = frac << 1;
        if (m >= (64'd1 << 31)) begin
          frac = frac | 1;
          m    = m >> 1;
        end
      end
      lg  = (longint'(e) - 16) * 65536 + longint'(frac);
      e16 = (-(beta * lg)) >>> 14;
      ei  = e16 >>> 16;
      ef  = e16 - ei * 65536;
      f   = 64'd1 << 30;
      c   = root_floor(64'd1 << 61);
      for (int i = 1; i <= 16; i++) begin
        if (((ef >> (16 - i)) & 1) != 0) f = (f * c) >> 30;
        c = root_floor(c << 30);
      end
      r  = mag * f;
      sh = 30 - ei;
      if (sh >= 64) r = 0;
      else if (sh >= 1) r = (r + (64'd1 << (sh - 1))) >> sh;
      else if (r != 0 && (-sh >= 63 || r > (lim >> (-sh)))) begin
        r   = lim;
        sat = 1'b1;
      end else r = r << (-sh);
      if (r > lim) begin
        r   = lim;
        sat = 1'b1;
      end
    end
    o.sample = neg ? SAMPLE_W'(64'd0 - r) : SAMPLE_W'(r);
    o.last   = 1'b0;
    o.sat    = sat;
    return o;
  endfunction

  task automatic take_word(input logic signed [SAMPLE_W-1:0] smp, input logic lst);
    int          p, n;
    longint      x;
    logic [63:0] mag;
    norm_word_t  o;
    p   = (eff_win() - 1) / 2;
    n   = 0;
    x   = longint'(smp);
    mag = x < 0 ? 64'(-x) : 64'(x);
    shift_in(mag * mag, x);
    pend++;
    if (pend > p) begin
      o = scale_sample(dly[p]);
      norm_q.push_back(o);
      n++;
      pend--;
    end
    if (lst) begin
      while (pend > 0) begin
        shift_in('0, 0);
        o = scale_sample(dly[p]);
        norm_q.push_back(o);
        n++;
        pend--;
      end
      norm_q[norm_q.size()-1].last = 1'b1;
      clear_stream();
    end
  endtask

  always @(posedge clk) begin
    norm_word_t exp_w;
    if (!rst_n) begin
      regs.win   = 4'd5;
      regs.alpha = 32'd85899;
      regs.beta  = 16'd12288;
      regs.bias  = 32'd65536;
      clear_stream();
      norm_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (norm_q.size() == 0) begin
          $error("unexpected result word: sample %0d last %0b", out_sample, out_last);
          fail_count++;
        end else begin
          exp_w = norm_q.pop_front();
          if (out_sample !== exp_w.sample) begin
            $error("out_sample expected %0d actual %0d",
                   $signed(exp_w.sample), out_sample);
            fail_count++;
          end
          if (out_last !== exp_w.last) begin
            $error("out_last expected %0b actual %0b", exp_w.last, out_last);
            fail_count++;
          end
          if (out_saturated !== exp_w.sat) begin
            $error("out_saturated expected %0b actual %0b", exp_w.sat, out_saturated);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) take_word(in_sample_in, in_last_channel);
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW: begin
            regs.win = cfg_data[3:0];
            clear_stream();
          end
          REG_ALPHA: regs.alpha = cfg_data;
          REG_BETA:  regs.beta  = cfg_data[15:0];
          REG_BIAS:  regs.bias  = cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/tb_lrn_across_channels.sv =====
`timescale 1ns / 1ps
// tb_lrn_across_channels: drives pixels of channel words and register settings into
// lrn_across_channels, with lrn_checker beside it; depends on lrn_pkg and both modules
module tb_lrn_across_channels;
  import lrn_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 200;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample_in = '0;
  logic                       in_last_channel = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_last;
  logic                       out_saturated;
  logic                       cfg_we = 1'b0;
  reg_idx_t                   cfg_index = REG_WINDOW;
  logic [CFG_W-1:0]           cfg_data = '0;
  int                         fail_count;
  int                         awaited;
  int                         cycles = 0;
  int                         burst_left = 0;
  int                         stall_mode = 0;

  always #2 clk = ~clk;

  lrn_across_channels dut (.*);
  lrn_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stall pattern: modes of free flow, light and heavy back-pressure
  always @(negedge clk) begin
    if (cycles % 64 == 0) stall_mode = $urandom_range(2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(9) < 2);
      default: out_stall <= ($urandom_range(9) < 7);
    endcase
  end

  task automatic send_word(input logic [SAMPLE_W-1:0] smp, input logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_sample_in    <= smp;
    in_last_channel <= lst;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
      @(negedge clk);
    end
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_all(input logic [3:0] w, input logic [31:0] a,
                         input logic [15:0] b, input logic [31:0] k);
    drain();
    write_reg(REG_WINDOW, CFG_W'(w));
    write_reg(REG_ALPHA, a);
    write_reg(REG_BETA, CFG_W'(b));
    write_reg(REG_BIAS, k);
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(5))
      0: return SAMPLE_W'($urandom_range(2) == 0 ? 16'h7FFF : 16'h8000);
      1: return SAMPLE_W'($urandom_range(511) - 256);
      2: return '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick32(input logic [31:0] usual);
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return usual;
      3: return $urandom_range(1 << 20);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int plen;
    int sent;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // extremes and a full pixel under reset settings
    send_word(16'h7FFF, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'h0001, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0100, 1'b0);
    send_word(16'hFF00, 1'b0);
    send_word(16'h4000, 1'b0);
    send_word(16'hC000, 1'b1);
    // single channel pixel, pixel shorter than the half window
    send_word(16'h0280, 1'b1);
    send_word(16'h8000, 1'b1);
    // window 0 behaves as 1, then an even window
    set_all(4'd0, 32'd85899, 16'd12288, 32'd65536);
    send_word(16'h1234, 1'b0);
    send_word(16'h8000, 1'b1);
    set_all(4'd4, 32'hFFFF_FFFF, 16'hFFFF, 32'd1);
    send_word(16'h7FFF, 1'b0);
    send_word(16'h0001, 1'b0);
    send_word(16'h8001, 1'b1);
    // zero scale with and without exponent
    set_all(4'd15, 32'd0, 16'd0, 32'd0);
    send_word(16'h8000, 1'b0);
    send_word(16'h0000, 1'b1);
    set_all(4'd15, 32'd0, 16'd16384, 32'd0);
    send_word(16'h0000, 1'b0);
    send_word(16'h0055, 1'b0);
    send_word(16'hFF01, 1'b1);
    // small bias with large exponent pushes the result above range
    set_all(4'd3, 32'd0, 16'hFFFF, 32'd256);
    send_word(16'h7FFF, 1'b0);
    send_word(16'h8000, 1'b1);

    sent = 0;
    while (sent < 460) begin
      set_all(4'($urandom_range(15)), pick32(32'd85899),
              ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(24576)),
              pick32(32'd65536));
      repeat ($urandom_range(4, 10)) begin
        plen = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 20);
        if (plen > 460 - sent) plen = 460 - sent;
        for (int c = 0; c < plen; c++) begin
          send_word(rand_sample(), c == plen - 1);
          sent++;
        end
      end
    end
    drain();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/lrn_pkg.sv
hdl/lrn_cell.sv
hdl/lrn_norm.sv
hdl/lrn_across_channels.sv
tb/lrn_checker.sv
tb/tb_lrn_across_channels.sv
